// ===== rtl/sc2a_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and character ROMs for the scancode decoder.
// No dependencies; used by sc2a_decode and scancode_to_ascii_decoder.
package sc2a_pkg;

  localparam int CodeW = 8;
  localparam int KeyW  = 7;
  localparam int CharW = 7;
  localparam int LockW = 3;
  localparam int ShftW = 2;

  localparam logic [KeyW-1:0] KEY_LSHIFT = 7'h2a;
  localparam logic [KeyW-1:0] KEY_RSHIFT = 7'h36;
  localparam logic [KeyW-1:0] KEY_CAPS   = 7'h3a;
  localparam logic [KeyW-1:0] KEY_NUM    = 7'h45;
  localparam logic [KeyW-1:0] KEY_SCROLL = 7'h46;

  localparam logic [LockW-1:0] LOCK_CAPS   = 3'b100;
  localparam logic [LockW-1:0] LOCK_NUM    = 3'b010;
  localparam logic [LockW-1:0] LOCK_SCROLL = 3'b001;

  localparam logic [CharW-1:0] CHAR_UPPER_A = 7'h41;
  localparam logic [CharW-1:0] CHAR_UPPER_Z = 7'h5a;
  localparam logic [CharW-1:0] CASE_OFFSET  = 7'h20;

  localparam logic [CodeW-1:0] LED_CMD_RESET = 8'd237;

  // configuration register indexes
  localparam logic CFG_INIT_LOCK = 1'b0;
  localparam logic CFG_LED_CMD   = 1'b1;

  // result kinds
  localparam logic KIND_KEY = 1'b0;
  localparam logic KIND_CMD = 1'b1;

  typedef struct packed {
    logic             pressed;
    logic [CharW-1:0] character;
    logic             is_letter;
    logic [KeyW-1:0]  key_number;
    logic             lock_press;
    logic [ShftW-1:0] shift_nxt;
    logic [LockW-1:0] lock_nxt;
  } dec_t;

  function automatic logic [CharW-1:0] rom_plain(input logic [KeyW-1:0] key);
    logic [CharW-1:0] ch;
    unique case (key)
      7'h02: ch = 7'h31;  7'h03: ch = 7'h32;  7'h04: ch = 7'h33;  7'h05: ch = 7'h34;
      7'h06: ch = 7'h35;  7'h07: ch = 7'h36;  7'h08: ch = 7'h37;  7'h09: ch = 7'h38;
      7'h0a: ch = 7'h39;  7'h0b: ch = 7'h30;  7'h0c: ch = 7'h2d;  7'h0d: ch = 7'h5e;
      7'h0e: ch = 7'h08;  7'h0f: ch = 7'h09;
      7'h10: ch = 7'h51;  7'h11: ch = 7'h57;  7'h12: ch = 7'h45;  7'h13: ch = 7'h52;
      7'h14: ch = 7'h54;  7'h15: ch = 7'h59;  7'h16: ch = 7'h55;  7'h17: ch = 7'h49;
      7'h18: ch = 7'h4f;  7'h19: ch = 7'h50;  7'h1a: ch = 7'h40;  7'h1b: ch = 7'h5b;
      7'h1c: ch = 7'h0a;  7'h1e: ch = 7'h41;  7'h1f: ch = 7'h53;
      7'h20: ch = 7'h44;  7'h21: ch = 7'h46;  7'h22: ch = 7'h47;  7'h23: ch = 7'h48;
      7'h24: ch = 7'h4a;  7'h25: ch = 7'h4b;  7'h26: ch = 7'h4c;  7'h27: ch = 7'h3b;
      7'h28: ch = 7'h3a;  7'h2b: ch = 7'h5d;  7'h2c: ch = 7'h5a;  7'h2d: ch = 7'h58;
      7'h2e: ch = 7'h43;  7'h2f: ch = 7'h56;
      7'h30: ch = 7'h42;  7'h31: ch = 7'h4e;  7'h32: ch = 7'h4d;  7'h33: ch = 7'h2c;
      7'h34: ch = 7'h2e;  7'h35: ch = 7'h2f;  7'h37: ch = 7'h2a;  7'h39: ch = 7'h20;
      7'h47: ch = 7'h37;  7'h48: ch = 7'h38;  7'h49: ch = 7'h39;  7'h4a: ch = 7'h2d;
      7'h4b: ch = 7'h34;  7'h4c: ch = 7'h35;  7'h4d: ch = 7'h36;  7'h4e: ch = 7'h2b;
      7'h4f: ch = 7'h31;
      7'h50: ch = 7'h32;  7'h51: ch = 7'h33;  7'h52: ch = 7'h30;  7'h53: ch = 7'h2e;
      default: ch = '0;
    endcase
    return ch;
  endfunction

  // shifted table: only the entries that differ from the plain one
  function automatic logic [CharW-1:0] rom_shifted(input logic [KeyW-1:0] key);
    logic [CharW-1:0] ch;
    unique case (key)
      7'h02: ch = 7'h21;  7'h03: ch = 7'h22;  7'h04: ch = 7'h23;  7'h05: ch = 7'h24;
      7'h06: ch = 7'h25;  7'h07: ch = 7'h26;  7'h08: ch = 7'h27;  7'h09: ch = 7'h28;
      7'h0a: ch = 7'h29;  7'h0b: ch = 7'h7e;  7'h0c: ch = 7'h3d;  7'h0d: ch = 7'h7e;
      7'h1a: ch = 7'h60;  7'h1b: ch = 7'h7b;  7'h27: ch = 7'h2b;  7'h28: ch = 7'h2a;
      7'h2b: ch = 7'h7d;  7'h33: ch = 7'h3c;  7'h34: ch = 7'h3e;  7'h35: ch = 7'h3f;
      7'h73: ch = 7'h5f;  7'h7d: ch = 7'h7c;
      default: ch = rom_plain(key);
    endcase
    return ch;
  endfunction

endpackage

// ===== rtl/sc2a_decode.sv =====
`timescale 1ns / 1ps
// Combinational decode of one scancode: shift/lock update and character lookup.
// Depends on sc2a_pkg.
module sc2a_decode (
  input  logic [sc2a_pkg::CodeW-1:0] code,
  input  logic [sc2a_pkg::ShftW-1:0] shift_bits,
  input  logic [sc2a_pkg::LockW-1:0] lock_bits,
  output sc2a_pkg::dec_t             dec
);
  import sc2a_pkg::*;

  logic [KeyW-1:0]  key;
  logic             pressed;
  logic [LockW-1:0] toggle;
  logic [ShftW-1:0] shift_nxt;
  logic [LockW-1:0] lock_nxt;
  logic [CharW-1:0] ch_raw;
  logic             letter;
  logic             lower;

  assign key     = code[KeyW-1:0];
  assign pressed = ~code[CodeW-1];

  always_comb begin
    shift_nxt = shift_bits;
    toggle    = '0;
    if (key == KEY_LSHIFT) begin
      shift_nxt[0] = pressed;
    end else if (key == KEY_RSHIFT) begin
      shift_nxt[1] = pressed;
    end else if (pressed && key == KEY_CAPS) begin
      toggle = LOCK_CAPS;
    end else if (pressed && key == KEY_NUM) begin
      toggle = LOCK_NUM;
    end else if (pressed && key == KEY_SCROLL) begin
      toggle = LOCK_SCROLL;
    end
  end

  assign lock_nxt = lock_bits ^ toggle;
  assign ch_raw   = (shift_nxt == '0) ? rom_plain(key) : rom_shifted(key);
  assign letter   = (ch_raw >= CHAR_UPPER_A) && (ch_raw <= CHAR_UPPER_Z);
  // lowercase when caps lock agrees with shift (both off or both on)
  assign lower    = letter && ((lock_nxt[2]) == (shift_nxt != '0));

  always_comb begin
    dec.pressed    = pressed;
    dec.character  = lower ? (ch_raw + CASE_OFFSET) : ch_raw;
    dec.is_letter  = letter;
    dec.key_number = key;
    dec.lock_press = (toggle != '0);
    dec.shift_nxt  = shift_nxt;
    dec.lock_nxt   = lock_nxt;
  end

endmodule

// ===== rtl/scancode_to_ascii_decoder.sv =====
`timescale 1ns / 1ps
// Set-1 scancode to ASCII decoder, top level.
// Depends on sc2a_pkg and sc2a_decode.

// Each accepted scancode gives one key result; a press of caps, num or scroll
// lock adds two command bytes (LED command, then the new lock bits), one per
// cycle while the output is not stalled. Other codes sustain one per cycle
// while the output is not stalled. The input register lets a new code be taken
// while a result waits on a stalled output; decoding holds while command bytes
// are still pending. Writing CFG_INIT_LOCK loads the lock state straight away,
// but a scancode decoded in the same cycle sets the lock state instead.
module scancode_to_ascii_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [sc2a_pkg::CodeW-1:0]   in_scancode,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_kind,
  output logic                         out_pressed,
  output logic [sc2a_pkg::CharW-1:0]   out_character,
  output logic                         out_is_letter,
  output logic [sc2a_pkg::KeyW-1:0]    out_key_number,
  output logic [sc2a_pkg::CodeW-1:0]   out_command_byte,
  output logic [sc2a_pkg::ShftW-1:0]   out_shift_state,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [sc2a_pkg::CodeW-1:0]   cfg_wdata
);
  import sc2a_pkg::*;

  typedef enum logic [1:0] {
    PEND_NONE,
    PEND_LED,
    PEND_LOCK
  } pend_t;

  pend_t              pend_r;
  logic               in_valid_r;
  logic [CodeW-1:0]   code_r;
  logic [ShftW-1:0]   shift_bits_r;
  logic [LockW-1:0]   lock_bits_r;
  logic [CodeW-1:0]   led_code_r;

  logic               out_valid_r;
  logic               kind_r;
  logic               pressed_r;
  logic [CharW-1:0]   character_r;
  logic               is_letter_r;
  logic [KeyW-1:0]    key_number_r;
  logic [CodeW-1:0]   command_byte_r;
  logic               last_r;

  dec_t               dec;
  logic               out_fire;
  logic               advance;

  sc2a_decode u_decode (
    .code       (code_r),
    .shift_bits (shift_bits_r),
    .lock_bits  (lock_bits_r),
    .dec        (dec)
  );

  assign out_fire = out_valid_r && !out_stall;
  // output register free for a new key result
  assign advance  = !out_valid_r || (out_fire && pend_r == PEND_NONE);
  assign in_stall = in_valid_r && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
      if (in_valid) begin
        code_r <= in_scancode;
      end
    end
  end

  // decoder state, configuration, output register and pending commands
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_bits_r <= '0;
      lock_bits_r  <= '0;
      led_code_r   <= LED_CMD_RESET;
      out_valid_r  <= 1'b0;
      pend_r       <= PEND_NONE;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_INIT_LOCK: lock_bits_r <= cfg_wdata[LockW-1:0];
          CFG_LED_CMD:   led_code_r  <= cfg_wdata;
          default:       led_code_r  <= led_code_r;
        endcase
      end
      if (in_valid_r && advance) begin
        shift_bits_r   <= dec.shift_nxt;
        lock_bits_r    <= dec.lock_nxt;
        out_valid_r    <= 1'b1;
        kind_r         <= KIND_KEY;
        pressed_r      <= dec.pressed;
        character_r    <= dec.character;
        is_letter_r    <= dec.is_letter;
        key_number_r   <= dec.key_number;
        command_byte_r <= '0;
        last_r         <= !dec.lock_press;
        pend_r         <= dec.lock_press ? PEND_LED : PEND_NONE;
      end else if (out_fire) begin
        unique case (pend_r)
          PEND_LED: begin
            kind_r         <= KIND_CMD;
            pressed_r      <= 1'b0;
            character_r    <= '0;
            is_letter_r    <= 1'b0;
            key_number_r   <= '0;
            command_byte_r <= led_code_r;
            last_r         <= 1'b0;
            pend_r         <= PEND_LOCK;
          end
          PEND_LOCK: begin
            kind_r         <= KIND_CMD;
            pressed_r      <= 1'b0;
            character_r    <= '0;
            is_letter_r    <= 1'b0;
            key_number_r   <= '0;
            command_byte_r <= {{(CodeW-LockW){1'b0}}, lock_bits_r};
            last_r         <= 1'b1;
            pend_r         <= PEND_NONE;
          end
          default: begin
            out_valid_r <= 1'b0;
          end
        endcase
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = kind_r;
  assign out_pressed      = pressed_r;
  assign out_character    = character_r;
  assign out_is_letter    = is_letter_r;
  assign out_key_number   = key_number_r;
  assign out_command_byte = command_byte_r;
  assign out_shift_state  = shift_bits_r;
  assign out_last         = last_r;

endmodule
